[sv/lehu_pkg.sv]
// lehu_pkg.sv: shared types and codes of the leader election unit
`timescale 1ns / 1ps
package lehu_pkg;

    localparam logic [2:0] CMD_ATTACH = 3'd0;
    localparam logic [2:0] CMD_DETACH = 3'd1;
    localparam logic [2:0] CMD_ELECT  = 3'd2;
    localparam logic [2:0] CMD_SETID  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    localparam logic [1:0] REG_VENDOR = 2'd0;
    localparam logic [1:0] REG_DEVICE = 2'd1;
    localparam logic [1:0] REG_MARGIN = 2'd2;
    localparam logic [1:0] REG_STREAK = 2'd3;

    localparam logic [15:0] VENDOR_RESET = 16'h1DA3;
    localparam logic [15:0] DEVICE_RESET = 16'h0001;
    localparam logic [7:0]  MARGIN_RESET = 8'd10;
    localparam logic [3:0]  STREAK_RESET = 4'd3;

    localparam logic [9:0] BENCH_WEIGHT = 10'd1000;
    localparam logic [9:0] PERCENT     = 10'd100;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  bus_num;
        logic [4:0]  dev_num;
        logic [2:0]  func_num;
        logic [15:0] vendor_code;
        logic [15:0] device_code;
        logic [31:0] mem_megabytes;
        logic [31:0] bench_value;
    } lehu_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot_index;
        logic [2:0] leader_index;
        logic       leader_valid;
        logic       leader_changed;
        logic [3:0] member_count;
    } lehu_out_t;

    typedef struct packed {
        logic addr_we;
        logic score_we;
    } lehu_wr_t;

endpackage

[sv/lehu_store.sv]
// lehu_store.sv: member address and score memories with one registered read port
`timescale 1ns / 1ps
module lehu_store import lehu_pkg::*; #(
    parameter int MEMBERS = 8
) (
    input  logic                       aclk,
    input  lehu_wr_t                   wr,
    input  logic [$clog2(MEMBERS)-1:0] wr_idx,
    input  logic [15:0]                wr_addr,
    input  logic [31:0]                wr_score,
    input  logic [$clog2(MEMBERS)-1:0] rd_idx,
    output logic [15:0]                rd_addr,
    output logic [31:0]                rd_score
);

    logic [15:0] addr_mem  [MEMBERS];
    logic [31:0] score_mem [MEMBERS];

    always_ff @(posedge aclk) begin
        if (wr.addr_we) begin
            addr_mem[wr_idx] <= wr_addr;
        end
        if (wr.score_we) begin
            score_mem[wr_idx] <= wr_score;
        end
        rd_addr  <= addr_mem[rd_idx];
        rd_score <= score_mem[rd_idx];
    end

endmodule

[sv/leader_election_hysteresis_unit.sv]
// leader_election_hysteresis_unit.sv: top level, command sequencer and shared datapath
//
// Keeps a table of MEMBERS member devices and elects a leader with hysteresis.
// Input beats (s_valid/s_ready, s_data) carry one command each; every command
// gives exactly one result beat (m_valid/m_ready, m_data).
// One command is worked on at a time; s_ready is high only while idle.
// Each table scan reads the shared memory port once per slot, and one shared
// 32x10 multiplier forms scores and margin products.
// Command length is set by the memory read port and the scans; a contested
// election adds the margin multiplies and a compare, and a clear needs no scan.
// The next command is taken while a result still waits: the result sits in an
// output register, and a command finishing while that result is untaken waits for m_ready.
// Reset (aresetn low, synchronous) empties the table, drops leader and
// challenger and loads the register defaults; slot memories are not cleared.
// Registers sit on an APB-style port at 4-byte steps: allowed vendor, allowed
// device, margin percent, streak needed. Write them only while idle.
`timescale 1ns / 1ps
module leader_election_hysteresis_unit import lehu_pkg::*; #(
    parameter int MEMBERS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lehu_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output lehu_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MEMBERS);
    localparam int SW = $clog2(MEMBERS + 1);
    localparam logic [SW-1:0] LAST = SW'(MEMBERS);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOKUP, S_DECIDE, S_SCORE_MUL, S_SCORE_WR, S_ELECT_SCAN,
        S_ELECT_DECIDE, S_MUL_CHAL, S_MUL_LEAD, S_COMPARE, S_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] vendor_reg, device_reg;
    logic [7:0]  margin_reg;
    logic [3:0]  streak_need_reg;

    // latched command
    logic [2:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [31:0] mem_reg, bench_reg;

    // table and election state
    logic [MEMBERS-1:0] used_reg;
    logic [SW-1:0]      count_reg;
    logic               leader_ok_reg, chal_ok_reg, was_ok_reg;
    logic [IW-1:0]      leader_reg, chal_reg, was_slot_reg;
    logic [3:0]         streak_reg;

    // scan
    logic [SW-1:0] scan_reg;
    logic [IW-1:0] idx_d_reg;
    logic          found_reg, free_ok_reg, best_ok_reg;
    logic [IW-1:0] found_idx_reg, free_idx_reg, best_idx_reg;
    logic [31:0]   best_score_reg;
    logic [15:0]   best_addr_reg;
    logic [1:0]    status_reg;
    logic [IW-1:0] slot_reg;
    logic [41:0]   lhs_reg, rhs_reg;

    logic          m_valid_reg;
    lehu_out_t     m_data_reg;

    // memory port
    lehu_wr_t      wr;
    logic [IW-1:0] wr_idx, rd_idx;
    logic [15:0]   rd_addr;
    logic [31:0]   rd_score;

    // shared multiplier
    logic [31:0] mul_a;
    logic [9:0]  mul_b;
    logic [41:0] product;

    logic        hit, better, margin_met;
    logic        chal_ok_next;
    logic [IW-1:0] chal_next;
    logic [3:0]  streak_next, need;

    assign wr.addr_we  = (state_reg == S_DECIDE) && (cmd_reg == CMD_ATTACH)
                         && !found_reg && free_ok_reg;
    assign wr.score_we = (state_reg == S_SCORE_WR);
    assign wr_idx = (state_reg == S_DECIDE) ? free_idx_reg : slot_reg;
    assign rd_idx = (state_reg == S_LOOKUP || state_reg == S_ELECT_SCAN)
                    ? scan_reg[IW-1:0] : leader_reg;

    lehu_store #(.MEMBERS(MEMBERS)) u_store (
        .aclk     (aclk),
        .wr       (wr),
        .wr_idx   (wr_idx),
        .wr_addr  (addr_reg),
        .wr_score (lhs_reg[31:0] + mem_reg),
        .rd_idx   (rd_idx),
        .rd_addr  (rd_addr),
        .rd_score (rd_score)
    );

    always_comb begin
        case (state_reg)
            S_SCORE_MUL: begin
                mul_a = bench_reg;
                mul_b = BENCH_WEIGHT;
            end
            S_MUL_CHAL: begin
                mul_a = best_score_reg;
                mul_b = PERCENT;
            end
            default: begin
                mul_a = rd_score;
                mul_b = PERCENT + 10'(margin_reg);
            end
        endcase
        product = 42'(mul_a) * 42'(mul_b);
    end

    assign hit    = used_reg[idx_d_reg] && (rd_addr == addr_reg);
    assign better = !best_ok_reg || (rd_score > best_score_reg)
                    || ((rd_score == best_score_reg) && (rd_addr < best_addr_reg));
    assign margin_met = (lhs_reg >= rhs_reg);
    assign need = (streak_need_reg == 4'd0) ? 4'd1 : streak_need_reg;

    // challenger update of one contested election
    always_comb begin
        chal_ok_next = 1'b0;
        chal_next    = '0;
        streak_next  = 4'd0;
        if (margin_met && chal_ok_reg && (chal_reg == best_idx_reg)) begin
            chal_ok_next = 1'b1;
            chal_next    = chal_reg;
            streak_next  = (streak_reg == 4'd15) ? streak_reg : streak_reg + 4'd1;
        end else if (margin_met) begin
            chal_ok_next = 1'b1;
            chal_next    = best_idx_reg;
            streak_next  = 4'd1;
        end
    end

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_VENDOR: prdata = {16'd0, vendor_reg};
            REG_DEVICE: prdata = {16'd0, device_reg};
            REG_MARGIN: prdata = {24'd0, margin_reg};
            REG_STREAK: prdata = {28'd0, streak_need_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vendor_reg      <= VENDOR_RESET;
            device_reg      <= DEVICE_RESET;
            margin_reg      <= MARGIN_RESET;
            streak_need_reg <= STREAK_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_VENDOR: vendor_reg      <= pwdata[15:0];
                REG_DEVICE: device_reg      <= pwdata[15:0];
                REG_MARGIN: margin_reg      <= pwdata[7:0];
                REG_STREAK: streak_need_reg <= pwdata[3:0];
                default:    ;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            count_reg     <= '0;
            leader_ok_reg <= 1'b0;
            leader_reg    <= '0;
            chal_ok_reg   <= 1'b0;
            chal_reg      <= '0;
            streak_reg    <= 4'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            // a finishing command reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            idx_d_reg <= scan_reg[IW-1:0];
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg      <= s_data.command;
                        addr_reg     <= {s_data.bus_num, s_data.dev_num, s_data.func_num};
                        mem_reg      <= s_data.mem_megabytes;
                        bench_reg    <= s_data.bench_value;
                        was_ok_reg   <= leader_ok_reg;
                        was_slot_reg <= leader_reg;
                        status_reg   <= ST_OK;
                        slot_reg     <= '0;
                        scan_reg     <= '0;
                        found_reg    <= 1'b0;
                        free_ok_reg  <= 1'b0;
                        best_ok_reg  <= 1'b0;
                        case (s_data.command)
                            CMD_ATTACH: begin
                                if (s_data.vendor_code != vendor_reg
                                    || s_data.device_code != device_reg) begin
                                    status_reg <= ST_REJECTED;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    state_reg <= S_LOOKUP;
                                end
                            end
                            CMD_DETACH, CMD_SETID: state_reg <= S_LOOKUP;
                            CMD_ELECT:             state_reg <= S_ELECT_SCAN;
                            CMD_CLEAR: begin
                                used_reg      <= '0;
                                count_reg     <= '0;
                                leader_ok_reg <= 1'b0;
                                leader_reg    <= '0;
                                chal_ok_reg   <= 1'b0;
                                chal_reg      <= '0;
                                streak_reg    <= 4'd0;
                                state_reg     <= S_FINISH;
                            end
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_LOOKUP: begin
                    // read data belongs to the previous scan index (idx_d_reg)
                    if (scan_reg != '0) begin
                        if (hit && !found_reg) begin
                            found_reg     <= 1'b1;
                            found_idx_reg <= idx_d_reg;
                        end
                        if (!used_reg[idx_d_reg] && !free_ok_reg) begin
                            free_ok_reg  <= 1'b1;
                            free_idx_reg <= idx_d_reg;
                        end
                    end
                    if (scan_reg == LAST) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        scan_reg <= scan_reg + SW'(1);
                    end
                end
                S_DECIDE: begin
                    scan_reg <= '0;
                    if (cmd_reg == CMD_ATTACH) begin
                        if (found_reg) begin
                            slot_reg  <= found_idx_reg;
                            state_reg <= S_FINISH;
                        end else if (!free_ok_reg) begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_FINISH;
                        end else begin
                            slot_reg               <= free_idx_reg;
                            used_reg[free_idx_reg] <= 1'b1;
                            count_reg              <= count_reg + SW'(1);
                            state_reg              <= S_SCORE_MUL;
                        end
                    end else if (!found_reg) begin
                        status_reg <= ST_MISSING;
                        state_reg  <= S_FINISH;
                    end else if (cmd_reg == CMD_DETACH) begin
                        slot_reg                <= found_idx_reg;
                        used_reg[found_idx_reg] <= 1'b0;
                        count_reg               <= count_reg - SW'(1);
                        if (leader_ok_reg && leader_reg == found_idx_reg) begin
                            leader_ok_reg <= 1'b0;
                            leader_reg    <= '0;
                            chal_ok_reg   <= 1'b0;
                            chal_reg      <= '0;
                            streak_reg    <= 4'd0;
                        end
                        state_reg <= S_ELECT_SCAN;
                    end else begin
                        slot_reg  <= found_idx_reg;
                        state_reg <= S_SCORE_MUL;
                    end
                end
                S_SCORE_MUL: begin
                    lhs_reg   <= product;
                    state_reg <= S_SCORE_WR;
                end
                S_SCORE_WR: begin
                    state_reg <= S_ELECT_SCAN;
                end
                S_ELECT_SCAN: begin
                    if (scan_reg != '0 && used_reg[idx_d_reg] && better) begin
                        best_ok_reg    <= 1'b1;
                        best_idx_reg   <= idx_d_reg;
                        best_score_reg <= rd_score;
                        best_addr_reg  <= rd_addr;
                    end
                    if (scan_reg == LAST) begin
                        state_reg <= S_ELECT_DECIDE;
                    end else begin
                        scan_reg <= scan_reg + SW'(1);
                    end
                end
                S_ELECT_DECIDE: begin
                    if (!best_ok_reg) begin
                        leader_ok_reg <= 1'b0;
                        leader_reg    <= '0;
                    end else if (!leader_ok_reg || !used_reg[leader_reg]) begin
                        leader_ok_reg <= 1'b1;
                        leader_reg    <= best_idx_reg;
                    end
                    if (!best_ok_reg || !leader_ok_reg || !used_reg[leader_reg]
                        || best_idx_reg == leader_reg) begin
                        chal_ok_reg <= 1'b0;
                        chal_reg    <= '0;
                        streak_reg  <= 4'd0;
                        state_reg   <= S_FINISH;
                    end else begin
                        // contested: leader score is read meanwhile
                        state_reg <= S_MUL_CHAL;
                    end
                end
                S_MUL_CHAL: begin
                    lhs_reg   <= product;
                    state_reg <= S_MUL_LEAD;
                end
                S_MUL_LEAD: begin
                    rhs_reg   <= product;
                    state_reg <= S_COMPARE;
                end
                S_COMPARE: begin
                    if (chal_ok_next && streak_next >= need) begin
                        leader_reg  <= best_idx_reg;
                        chal_ok_reg <= 1'b0;
                        chal_reg    <= '0;
                        streak_reg  <= 4'd0;
                    end else begin
                        chal_ok_reg <= chal_ok_next;
                        chal_reg    <= chal_next;
                        streak_reg  <= streak_next;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.status         <= status_reg;
                        m_data_reg.slot_index     <= 3'(slot_reg);
                        m_data_reg.leader_index   <= leader_ok_reg ? 3'(leader_reg) : 3'd0;
                        m_data_reg.leader_valid   <= leader_ok_reg;
                        m_data_reg.leader_changed <= (was_ok_reg != leader_ok_reg)
                            || (leader_ok_reg && was_slot_reg != leader_reg);
                        m_data_reg.member_count   <= 4'(count_reg);
                        state_reg                 <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'($countones(used_reg)) == count_reg)
        else $error("member count out of step with slot bits");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while busy");

    a_leader_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) && leader_ok_reg |-> used_reg[leader_reg])
        else $error("leader slot not in use");

    a_challenger_not_leader: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) && chal_ok_reg |-> leader_ok_reg && chal_reg != leader_reg)
        else $error("challenger without distinct leader");

endmodule
